// ===== hdl/wrf_pkg.sv =====
`default_nettype none
package wrf_pkg;

	localparam int PIX_W     = 24;
	localparam int MAX_WIDTH = 1024;
	localparam int ADDR_W    = $clog2(MAX_WIDTH);
	localparam int WIN       = 3;
	localparam int NWIN      = WIN * WIN;
	localparam int CNT_W     = $clog2(NWIN);
	localparam int WIDTH_W   = 11;
	localparam int HEIGHT_W  = 16;
	localparam int RANK_W    = 4;
	localparam int X_W       = 10;
	localparam int Y_W       = 16;
	localparam int CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RANK     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BOUNDARY = 2'd3;

	// input kinds
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_FLUSH  = 1'b1;

	typedef logic signed [PIX_W-1:0] pix_t;
	typedef logic [WIN-1:0][PIX_W-1:0] col_t;
	typedef logic [NWIN-1:0][PIX_W-1:0] win_t;

	// results one item causes, carried down the pipeline
	typedef struct packed {
		logic           emit_a;
		logic           emit_b;
		logic           a_rank;
		logic           frame_end;
		logic [X_W-1:0] xa;
		logic [X_W-1:0] xb;
		logic [Y_W-1:0] y;
	} desc_t;

endpackage
`default_nettype wire

// ===== hdl/wrf_if.sv =====
`default_nettype none
interface wrf_in_if import wrf_pkg::*; ();
	logic valid;
	logic ready;
	logic kind;
	pix_t sample;
	modport source (output valid, kind, sample, input ready);
	modport sink (input valid, kind, sample, output ready);
endinterface

interface wrf_out_if import wrf_pkg::*; ();
	logic           valid;
	logic           ready;
	logic [X_W-1:0] out_x;
	logic [Y_W-1:0] out_y;
	pix_t           filtered;
	logic           frame_end;
	modport source (output valid, out_x, out_y, filtered, frame_end, input ready);
	modport sink (input valid, out_x, out_y, filtered, frame_end, output ready);
endinterface
`default_nettype wire

// ===== hdl/wrf_col_cell.sv =====
`default_nettype none
module wrf_col_cell import wrf_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire col_t d,
	output col_t      q
);

	col_t col_q;

	// one window column, handed on to the next cell on each shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (en) begin
			col_q <= d;
		end
	end

	assign q = col_q;

endmodule
`default_nettype wire

// ===== hdl/wrf_rank.sv =====
`default_nettype none
module wrf_rank import wrf_pkg::*; (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire win_t              win,
	input  wire logic [CNT_W-1:0]  rank,
	output pix_t                   sel
);

	logic [NWIN-1:0][CNT_W-1:0] pos_s3;
	win_t                       vals_s3;
	logic [NWIN-1:0][CNT_W-1:0] pos;

	// sorted position of each element; ties broken by index
	always_comb begin
		for (int i = 0; i < NWIN; i++) begin
			pos[i] = '0;
			for (int j = 0; j < NWIN; j++) begin
				if (($signed(win[j]) < $signed(win[i])) ||
				    (j < i && win[j] == win[i])) begin
					pos[i] = pos[i] + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s3  <= pos;
			vals_s3 <= win;
		end
	end

	// exactly one element holds each position
	always_comb begin
		sel = '0;
		for (int i = 0; i < NWIN; i++) begin
			if (pos_s3[i] == rank) begin
				sel = sel | pix_t'(vals_s3[i]);
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/window_rank_filter.sv =====
// 3x3 rank-order filter over a raster height map.
// Input channel in_ch: kind 0 carries one signed 16.8 sample, kind 1 is a
// flush tick that drains the last row after the frame has fully arrived.
// Output channel out_ch: one pixel per item with its column, row, value
// and a frame_end mark on the final pixel of the frame.
// Configuration: cfg_we/cfg_index/cfg_data write width, height, rank and
// boundary value; write only while the block is idle.
// Each pixel of a row but the last leaves one line and one pixel after its
// centre sample; the last leaves one line after it. Pipeline: accept with
// line memory read, window shift, rank compare and output register.
// Throughput is one item per cycle while out_ch is ready; a row-end item
// gives two results, which leave in turn from the single output register.
// When out_ch stalls, the pipeline holds and in_ch.ready drops once all
// stages are full. Reset clears counters, window and configuration to their
// defaults; line memory content is left undefined and needs no clearing.
`default_nettype none
module window_rank_filter import wrf_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [PIX_W-1:0]     cfg_data,
	wrf_in_if.sink                    in_ch,
	wrf_out_if.source                 out_ch
);

	// configuration
	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [RANK_W-1:0]   rank_q;
	pix_t                bnd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_W'(1024);
			height_q <= HEIGHT_W'(1024);
			rank_q   <= RANK_W'(4);
			bnd_q    <= pix_t'(-8388608);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH:    width_q  <= cfg_data[WIDTH_W-1:0];
				REG_HEIGHT:   height_q <= cfg_data[HEIGHT_W-1:0];
				REG_RANK:     rank_q   <= cfg_data[RANK_W-1:0];
				REG_BOUNDARY: bnd_q    <= pix_t'(cfg_data);
				default: ;
			endcase
		end
	end

	logic [WIDTH_W-1:0]  w_eff;
	logic [X_W-1:0]      wm1;
	logic [HEIGHT_W-1:0] h_eff;
	logic [CNT_W-1:0]    rank_eff;

	assign w_eff    = (width_q == '0) ? WIDTH_W'(1) :
	                  (width_q > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH) : width_q;
	assign wm1      = X_W'(w_eff - WIDTH_W'(1));
	assign h_eff    = (height_q == '0) ? HEIGHT_W'(1) : height_q;
	assign rank_eff = (rank_q >= RANK_W'(NWIN)) ? CNT_W'(NWIN - 1) : CNT_W'(rank_q);

	// handshake and stage control
	logic s1_valid_q, s2_valid_q, s3_valid_q;
	logic pend_a_q, pend_b_q;
	logic out_fire, out_free, adv1, adv2, adv3, s1_free, s2_free, s3_free;
	logic accept;

	assign out_fire = out_ch.valid && out_ch.ready;
	assign out_free = (!pend_a_q && !pend_b_q) || (out_fire && !(pend_a_q && pend_b_q));
	assign adv3     = s3_valid_q && out_free;
	assign s3_free  = !s3_valid_q || adv3;
	assign adv2     = s2_valid_q && s3_free;
	assign s2_free  = !s2_valid_q || adv2;
	assign adv1     = s1_valid_q && s2_free;
	assign s1_free  = !s1_valid_q || adv1;
	assign in_ch.ready = s1_free;
	assign accept   = in_ch.valid && s1_free;

	// position counters
	logic [X_W-1:0] col_q;
	logic [Y_W-1:0] row_q;
	logic [X_W-1:0] drain_q;
	logic           frame_done, is_flush, take_sample, take_flush;
	logic [X_W-1:0] cx, p;
	logic           last_px, row_end;

	assign frame_done  = row_q >= h_eff;
	assign is_flush    = (in_ch.kind == KIND_FLUSH);
	assign take_sample = accept && !is_flush && !frame_done;
	assign take_flush  = accept && is_flush && frame_done;
	assign cx          = ({1'b0, col_q} >= w_eff) ? wm1 : col_q;
	assign p           = ({1'b0, drain_q} >= w_eff) ? wm1 : drain_q;
	assign last_px     = ({1'b0, p} + WIDTH_W'(1)) >= w_eff;
	assign row_end     = (cx == wm1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			drain_q <= '0;
		end else if (take_flush) begin
			if (last_px) begin
				col_q   <= '0;
				row_q   <= '0;
				drain_q <= '0;
			end else begin
				drain_q <= p + X_W'(1);
			end
		end else if (take_sample) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= row_q + Y_W'(1);
			end else begin
				col_q <= cx + X_W'(1);
			end
		end
	end

	// results this item causes
	desc_t desc_in;

	always_comb begin
		desc_in = '0;
		if (is_flush) begin
			desc_in.emit_a    = 1'b1;
			desc_in.frame_end = last_px;
			desc_in.xa        = p;
			desc_in.y         = h_eff - Y_W'(1);
		end else begin
			desc_in.emit_a = (row_q != '0) && (cx != '0);
			desc_in.emit_b = (row_q != '0) && row_end;
			desc_in.a_rank = (row_q >= Y_W'(2)) && (cx >= X_W'(2));
			desc_in.xa     = cx - X_W'(1);
			desc_in.xb     = cx;
			desc_in.y      = row_q - Y_W'(1);
		end
	end

	// line memories, stage 1
	pix_t line0_mem [MAX_WIDTH];
	pix_t line1_mem [MAX_WIDTH];
	pix_t rd0_s1, rd1_s1, smp_s1, hold_q;
	logic [ADDR_W-1:0] cx_s1;
	logic  sample_s1, fwd_s1;
	desc_t desc_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			rd0_s1 <= line0_mem[cx];
			rd1_s1 <= line1_mem[cx];
		end
		if (take_sample) begin
			line0_mem[cx] <= in_ch.sample;
		end
		if (adv1 && sample_s1) begin
			line1_mem[cx_s1] <= rd0_s1;
		end
		if (adv1) begin
			hold_q <= rd0_s1;
		end
		if (accept) begin
			smp_s1    <= in_ch.sample;
			cx_s1     <= cx;
			sample_s1 <= !is_flush;
			desc_s1   <= desc_in;
			fwd_s1    <= s1_valid_q && sample_s1 && (cx_s1 == cx) && !is_flush;
		end
	end

	// window cells
	col_t col_new, col_c0, col_c1, col_c2;

	assign col_new = {smp_s1, rd0_s1, (fwd_s1 ? hold_q : rd1_s1)};

	wrf_col_cell u_cell0 (.clk(clk), .arst_n(arst_n), .en(adv1 && sample_s1),
		.d(col_new), .q(col_c0));
	wrf_col_cell u_cell1 (.clk(clk), .arst_n(arst_n), .en(adv1 && sample_s1),
		.d(col_c0), .q(col_c1));
	wrf_col_cell u_cell2 (.clk(clk), .arst_n(arst_n), .en(adv1 && sample_s1),
		.d(col_c1), .q(col_c2));

	desc_t desc_s2, desc_s3;
	win_t  win;
	pix_t  rank_val;

	assign win = {col_c2, col_c1, col_c0};

	always_ff @(posedge clk) begin
		if (adv1) begin
			desc_s2 <= desc_s1;
		end
		if (adv2) begin
			desc_s3 <= desc_s2;
		end
	end

	wrf_rank u_rank (.clk(clk), .en(adv2), .win(win), .rank(rank_eff), .sel(rank_val));

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
			s3_valid_q <= 1'b0;
		end else begin
			if (s1_free) begin
				s1_valid_q <= take_sample || take_flush;
			end
			if (s2_free) begin
				s2_valid_q <= adv1;
			end
			if (s3_free) begin
				s3_valid_q <= adv2;
			end
		end
	end

	// output register, up to two results
	logic [X_W-1:0] xa_q, xb_q;
	logic [Y_W-1:0] y_q;
	logic           fe_q;
	pix_t           fa_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_a_q <= 1'b0;
			pend_b_q <= 1'b0;
		end else if (adv3) begin
			pend_a_q <= desc_s3.emit_a;
			pend_b_q <= desc_s3.emit_b;
		end else if (out_fire) begin
			if (pend_a_q) begin
				pend_a_q <= 1'b0;
			end else begin
				pend_b_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			xa_q <= desc_s3.xa;
			xb_q <= desc_s3.xb;
			y_q  <= desc_s3.y;
			fe_q <= desc_s3.frame_end;
			fa_q <= desc_s3.a_rank ? rank_val : bnd_q;
		end
	end

	assign out_ch.valid     = pend_a_q || pend_b_q;
	assign out_ch.out_x     = pend_a_q ? xa_q : xb_q;
	assign out_ch.out_y     = y_q;
	assign out_ch.filtered  = pend_a_q ? fa_q : bnd_q;
	assign out_ch.frame_end = pend_a_q && fe_q;

endmodule
`default_nettype wire
